// ===== rtl/bia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and codes of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int WORD_BITS = 64;

  localparam logic       OP_ALLOCATE = 1'b0;
  localparam logic       OP_RELEASE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  localparam logic       CFG_RANGE_LOW  = 1'b0;
  localparam logic       CFG_RANGE_HIGH = 1'b1;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_GRANT  = 7'b0010000,
    S_FREE   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

endpackage

// ===== rtl/bia_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Next-fit identifier allocator over a used-bit map held in one RAM.
// An allocate scans one 64-bit map word per cycle through a priority encoder,
// 16 words per pass at the default. A release goes through check and read,
// write and result steps; an invalid request goes from the check straight to
// the result. One transfer is in flight at a time; the result register lets
// the next transfer start while a result waits. After reset a clearing pass
// writes ceil(MAX_IDS / 64) words, one per cycle, while in_stall_o stays high.
// ----------------------------------------------------------------------------
module bitmap_id_allocator #(
  parameter int MAX_IDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_opcode_i,
  input  logic [31:0] in_release_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_status_o,
  output logic [31:0] out_granted_id_o
);

  localparam int WORDS = (MAX_IDS + 63) / 64;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_IDS + 1);

  bia_pkg::state_e state_q, state_d;

  logic [31:0]      range_low_q, range_high_q;
  logic [WA_W-1:0]  clr_word_q, clr_word_d;
  logic [WA_W-1:0]  hint_word_q, hint_word_d;
  logic [5:0]       hint_bit_q, hint_bit_d;
  logic             out_vld_q, out_vld_d;
  logic             rd_done_q, rd_done_d;
  logic             chk_vld_q, chk_vld_d;
  logic             phase_q, phase_d;

  logic             opcode_q, opcode_d;
  logic [31:0]      rid_q, rid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WA_W-1:0]  rel_word_q, rel_word_d;
  logic [5:0]       rel_bit_q, rel_bit_d;
  logic [WA_W-1:0]  start_word_q, start_word_d;
  logic [5:0]       start_bit_q, start_bit_d;
  logic [WA_W-1:0]  rd_word_q, rd_word_d;
  logic [WA_W-1:0]  chk_word_q, chk_word_d;
  logic [WA_W-1:0]  fnd_word_q, fnd_word_d;
  logic [5:0]       fnd_bit_q, fnd_bit_d;
  logic [63:0]      wdata_q, wdata_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [31:0]      res_id_q, res_id_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [31:0]      out_id_q, out_id_d;

  logic             mem_we, mem_re;
  logic [WA_W-1:0]  mem_waddr, mem_raddr;
  logic [63:0]      mem_wdata, mem_rdata;

  logic [31:0]      diff, cnt_m1, rel_off;
  logic [WA_W-1:0]  last_word;
  logic [5:0]       last_bit;
  logic             rel_invalid, hint_past;
  logic [63:0]      lo_mask, hi_mask, cand;
  logic [5:0]       enc;
  logic             found;

  bia_ram #(
    .WIDTH (64),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= 32'd0;
      range_high_q <= 32'd1023;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == bia_pkg::CFG_RANGE_LOW) begin
        range_low_q <= cfg_wdata_i;
      end else begin
        range_high_q <= cfg_wdata_i;
      end
    end
  end

  assign diff      = range_high_q - range_low_q;
  assign cnt_m1    = 32'(cnt_q) - 32'd1;
  assign last_word = cnt_m1[WA_W+5:6];
  assign last_bit  = cnt_m1[5:0];
  assign rel_off   = rid_q - range_low_q;
  assign rel_invalid = (rid_q < range_low_q) || (rid_q > range_high_q) ||
                       (rel_off >= 32'(cnt_q));
  assign hint_past = 32'({hint_word_q, hint_bit_q}) >= 32'(cnt_q);

  always_comb begin
    lo_mask = '1;
    hi_mask = '1;
    if (chk_word_q == start_word_q) begin
      lo_mask = {64{1'b1}} << start_bit_q;
    end
    if (chk_word_q == last_word) begin
      hi_mask = {64{1'b1}} >> (6'd63 - last_bit);
    end
    cand  = ~mem_rdata & lo_mask & hi_mask;
    found = |cand;
    enc   = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (cand[i]) begin
        enc = 6'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_word_d   = clr_word_q;
    hint_word_d  = hint_word_q;
    hint_bit_d   = hint_bit_q;
    out_vld_d    = out_vld_q && out_stall_i;
    rd_done_d    = rd_done_q;
    chk_vld_d    = 1'b0;
    phase_d      = phase_q;
    opcode_d     = opcode_q;
    rid_d        = rid_q;
    cnt_d        = cnt_q;
    rel_word_d   = rel_word_q;
    rel_bit_d    = rel_bit_q;
    start_word_d = start_word_q;
    start_bit_d  = start_bit_q;
    rd_word_d    = rd_word_q;
    chk_word_d   = chk_word_q;
    fnd_word_d   = fnd_word_q;
    fnd_bit_d    = fnd_bit_q;
    wdata_d      = wdata_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_word_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = rd_word_q;

    case (state_q)
      bia_pkg::S_CLEAR: begin
        mem_we     = 1'b1;
        clr_word_d = clr_word_q + 1'b1;
        if (clr_word_q == WA_W'(WORDS - 1)) begin
          state_d = bia_pkg::S_IDLE;
        end
      end
      bia_pkg::S_IDLE: begin
        if (in_valid_i) begin
          opcode_d = in_opcode_i;
          rid_d    = in_release_id_i;
          if (range_low_q > range_high_q) begin
            cnt_d = '0;
          end else if (diff >= 32'(MAX_IDS - 1)) begin
            cnt_d = CNT_W'(MAX_IDS);
          end else begin
            cnt_d = CNT_W'(diff) + 1'b1;
          end
          state_d = bia_pkg::S_PREP;
        end
      end
      bia_pkg::S_PREP: begin
        res_id_d = '0;
        if (opcode_q == bia_pkg::OP_RELEASE) begin
          if (rel_invalid) begin
            res_status_d = bia_pkg::ST_INVALID;
            state_d      = bia_pkg::S_RESP;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = rel_off[WA_W+5:6];
            rel_word_d = rel_off[WA_W+5:6];
            rel_bit_d  = rel_off[5:0];
            state_d    = bia_pkg::S_FREE;
          end
        end else if (cnt_q == '0) begin
          res_status_d = bia_pkg::ST_NOSPACE;
          state_d      = bia_pkg::S_RESP;
        end else begin
          if (hint_past) begin
            phase_d      = 1'b1;
            start_word_d = '0;
            start_bit_d  = '0;
          end else begin
            phase_d      = 1'b0;
            start_word_d = hint_word_q;
            start_bit_d  = hint_bit_q;
          end
          rd_word_d = hint_past ? '0 : hint_word_q;
          rd_done_d = 1'b0;
          state_d   = bia_pkg::S_SCAN;
        end
      end
      bia_pkg::S_SCAN: begin
        if (!rd_done_q) begin
          mem_re     = 1'b1;
          rd_done_d  = (rd_word_q == last_word);
          rd_word_d  = rd_word_q + 1'b1;
          chk_vld_d  = 1'b1;
          chk_word_d = rd_word_q;
        end
        if (chk_vld_q) begin
          if (found) begin
            fnd_word_d = chk_word_q;
            fnd_bit_d  = enc;
            wdata_d    = mem_rdata | (64'd1 << enc);
            chk_vld_d  = 1'b0;
            state_d    = bia_pkg::S_GRANT;
          end else if (chk_word_q == last_word) begin
            chk_vld_d = 1'b0;
            if (!phase_q) begin
              phase_d      = 1'b1;
              start_word_d = '0;
              start_bit_d  = '0;
              rd_word_d    = '0;
              rd_done_d    = 1'b0;
            end else begin
              res_status_d = bia_pkg::ST_NOSPACE;
              res_id_d     = '0;
              state_d      = bia_pkg::S_RESP;
            end
          end
        end
      end
      bia_pkg::S_GRANT: begin
        mem_we       = 1'b1;
        mem_waddr    = fnd_word_q;
        mem_wdata    = wdata_q;
        hint_word_d  = fnd_word_q;
        hint_bit_d   = fnd_bit_q;
        res_status_d = bia_pkg::ST_OK;
        res_id_d     = range_low_q + 32'({fnd_word_q, fnd_bit_q});
        state_d      = bia_pkg::S_RESP;
      end
      bia_pkg::S_FREE: begin
        mem_we       = 1'b1;
        mem_waddr    = rel_word_q;
        mem_wdata    = mem_rdata & ~(64'd1 << rel_bit_q);
        res_status_d = bia_pkg::ST_OK;
        res_id_d     = '0;
        state_d      = bia_pkg::S_RESP;
      end
      bia_pkg::S_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          state_d      = bia_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bia_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bia_pkg::S_CLEAR;
      clr_word_q  <= '0;
      hint_word_q <= '0;
      hint_bit_q  <= '0;
      out_vld_q   <= 1'b0;
      rd_done_q   <= 1'b0;
      chk_vld_q   <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_word_q  <= clr_word_d;
      hint_word_q <= hint_word_d;
      hint_bit_q  <= hint_bit_d;
      out_vld_q   <= out_vld_d;
      rd_done_q   <= rd_done_d;
      chk_vld_q   <= chk_vld_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opcode_q     <= opcode_d;
    rid_q        <= rid_d;
    cnt_q        <= cnt_d;
    rel_word_q   <= rel_word_d;
    rel_bit_q    <= rel_bit_d;
    start_word_q <= start_word_d;
    start_bit_q  <= start_bit_d;
    rd_word_q    <= rd_word_d;
    chk_word_q   <= chk_word_d;
    fnd_word_q   <= fnd_word_d;
    fnd_bit_q    <= fnd_bit_d;
    wdata_q      <= wdata_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  assign in_stall_o       = (state_q != bia_pkg::S_IDLE);
  assign out_valid_o      = out_vld_q;
  assign out_status_o     = out_status_q;
  assign out_granted_id_o = out_id_q;

endmodule

// ===== rtl/bia_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_checker
// Port-level checks of the bitmap identifier allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  out_status_o,
  input logic [31:0] out_granted_id_o
);

  // A stalled result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o) &&
    $stable(out_granted_id_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o != 2'd3)
    else $error("undefined status code");

  // Only a successful grant carries a nonzero identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != bia_pkg::ST_OK) |-> out_granted_id_o == 32'd0)
    else $error("identifier on a failed request");

  // An accepted transfer keeps the input side busy for its work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after a transfer");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_status_o     (out_status_o),
  .out_granted_id_o (out_granted_id_o)
);

// ===== tb/bitmap_id_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_checker
// Watches the request, result and register ports of the identifier allocator.
// It keeps its own copy of the used map, the next-fit hint and the range,
// works out the answer to every accepted request and compares each result
// transfer, field by field, with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_checker #(
  parameter int IdCapacity = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_opcode_i,
  input  logic [31:0] in_release_id_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  out_status_i,
  input  logic [31:0] out_granted_id_i,
  output int          fail_count_o,
  output int          pending_count_o,
  output int          grants_o,
  output int          no_space_o,
  output int          invalid_o
);

  typedef struct packed {
    logic        is_alloc;
    logic [1:0]  status;
    logic [31:0] granted_id;
  } id_answer_t;

  logic        id_taken [IdCapacity];
  logic [9:0]  next_fit_hint;
  logic [31:0] range_low;
  logic [31:0] range_high;
  id_answer_t  awaited_answers [$];
  int          mismatches;
  int          grant_total;
  int          no_space_total;
  int          invalid_total;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Updates the allocator copy and returns the status; the grant comes back
  // through the output argument.
  function automatic logic [1:0] compute_answer(input logic opcode,
                                                input logic [31:0] rid,
                                                output logic [31:0] grant);
    logic [32:0] width;
    int unsigned usable;
    int unsigned off;
    int unsigned probe;
    logic        found;
    grant = '0;
    found = 1'b0;
    off = 0;
    usable = 0;
    if (range_low <= range_high) begin
      width = {1'b0, range_high} - {1'b0, range_low} + 33'd1;
      usable = (width > IdCapacity) ? IdCapacity : int'(width);
    end
    if (opcode == bia_pkg::OP_ALLOCATE) begin
      for (probe = next_fit_hint; probe < usable && !found; probe++) begin
        if (!id_taken[probe]) begin
          off = probe;
          found = 1'b1;
        end
      end
      for (probe = 0; probe < usable && !found; probe++) begin
        if (!id_taken[probe]) begin
          off = probe;
          found = 1'b1;
        end
      end
      if (!found) return bia_pkg::ST_NOSPACE;
      id_taken[off] = 1'b1;
      next_fit_hint = off[9:0];
      grant = range_low + off;
      return bia_pkg::ST_OK;
    end
    if (rid < range_low || rid > range_high) return bia_pkg::ST_INVALID;
    off = rid - range_low;
    if (off >= usable) return bia_pkg::ST_INVALID;
    id_taken[off] = 1'b0;
    return bia_pkg::ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    id_answer_t want;
    if (!rst_ni) begin
      foreach (id_taken[i]) id_taken[i] = 1'b0;
      next_fit_hint = '0;
      range_low = 32'd0;
      range_high = 32'd1023;
      awaited_answers.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("result status %0d id %h with nothing outstanding",
                                    out_status_i, out_granted_id_i));
        end else begin
          want = awaited_answers.pop_front();
          if (out_status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status_i,
                                      want.status));
          if (out_granted_id_i !== want.granted_id)
            report_mismatch($sformatf("granted id %h, expected %h", out_granted_id_i,
                                      want.granted_id));
          case (want.status)
            bia_pkg::ST_OK:      if (want.is_alloc) grant_total++;
            bia_pkg::ST_NOSPACE: no_space_total++;
            default:             invalid_total++;
          endcase
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bia_pkg::CFG_RANGE_LOW:  range_low = cfg_wdata_i;
          bia_pkg::CFG_RANGE_HIGH: range_high = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        want.is_alloc = (in_opcode_i == bia_pkg::OP_ALLOCATE);
        want.status = compute_answer(in_opcode_i, in_release_id_i, want.granted_id);
        awaited_answers.push_back(want);
      end
    end
    fail_count_o <= mismatches;
    pending_count_o <= awaited_answers.size();
    grants_o <= grant_total;
    no_space_o <= no_space_total;
    invalid_o <= invalid_total;
  end

endmodule

// ===== tb/bitmap_id_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_test
// Drives allocate and release requests into the identifier allocator under
// several identifier ranges: a directed opening over the range edges, empty
// and oversized ranges, then random traffic with idle cycles on either side
// and one long result hold-off. A separate checker predicts every answer.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_test;

  localparam int IdCapacity   = 1024;
  localparam int QuietLimit   = 4000;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 48;
  localparam int TailCycles   = 48;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = bia_pkg::CFG_RANGE_LOW;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = bia_pkg::OP_ALLOCATE;
  logic [31:0] in_release_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_granted_id;

  int          fail_count;
  int          pending;
  int          grants;
  int          no_space;
  int          invalid;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 61;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [31:0] cur_low = 32'd0;
  logic [31:0] cur_high = 32'd1023;
  int          allocs = 0;
  int          releases = 0;
  int          range_settings = 1;

  bitmap_id_allocator #(
    .MAX_IDS(IdCapacity)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_opcode_i     (in_opcode),
    .in_release_id_i (in_release_id),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_status_o    (out_status),
    .out_granted_id_o(out_granted_id)
  );

  bitmap_id_allocator_checker #(
    .IdCapacity(IdCapacity)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_opcode_i     (in_opcode),
    .in_release_id_i (in_release_id),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_status_i    (out_status),
    .out_granted_id_i(out_granted_id),
    .fail_count_o    (fail_count),
    .pending_count_o (pending),
    .grants_o        (grants),
    .no_space_o      (no_space),
    .invalid_o       (invalid)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("bitmap_id_allocator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue_request(input logic opcode, input logic [31:0] rid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_opcode <= opcode;
    in_release_id <= rid;
    do @(posedge clk_i); while (in_stall);
    if (opcode == bia_pkg::OP_ALLOCATE) allocs++;
    else releases++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // The range registers change only once every answer is back.
  task automatic set_range(input logic [31:0] low, input logic [31:0] high);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= bia_pkg::CFG_RANGE_LOW;
    cfg_wdata <= low;
    @(posedge clk_i);
    cfg_addr <= bia_pkg::CFG_RANGE_HIGH;
    cfg_wdata <= high;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_low = low;
    cur_high = high;
    range_settings++;
  endtask

  task automatic random_requests(input int count);
    logic [32:0] width;
    int          span;
    int          pick;
    int          n;
    width = {1'b0, cur_high} - {1'b0, cur_low} + 33'd1;
    span = (width > IdCapacity + 64) ? IdCapacity + 64 : int'(width);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) issue_request(bia_pkg::OP_ALLOCATE, $urandom());
      else if (pick < 88) issue_request(bia_pkg::OP_RELEASE,
                                        cur_low + $urandom_range(span - 1));
      else if (pick < 91) issue_request(bia_pkg::OP_RELEASE, cur_low - 32'd1);
      else if (pick < 94) issue_request(bia_pkg::OP_RELEASE, cur_high + 32'd1);
      else issue_request(bia_pkg::OP_RELEASE, $urandom());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset range of 0 to 1023, then the register extremes.
    issue_request(bia_pkg::OP_ALLOCATE, 32'd0);
    issue_request(bia_pkg::OP_ALLOCATE, 32'd0);
    issue_request(bia_pkg::OP_ALLOCATE, 32'hFFFF_FFFF);
    issue_request(bia_pkg::OP_RELEASE, 32'd1);
    issue_request(bia_pkg::OP_RELEASE, 32'd1);
    issue_request(bia_pkg::OP_RELEASE, 32'd1023);
    issue_request(bia_pkg::OP_RELEASE, 32'd1024);
    issue_request(bia_pkg::OP_RELEASE, 32'hFFFF_FFFF);
    issue_request(bia_pkg::OP_ALLOCATE, 32'h5555_5555);

    set_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    issue_request(bia_pkg::OP_ALLOCATE, 32'hAAAA_AAAA);
    issue_request(bia_pkg::OP_ALLOCATE, 32'd0);
    issue_request(bia_pkg::OP_RELEASE, 32'hFFFF_FFFF);
    issue_request(bia_pkg::OP_RELEASE, 32'd0);

    // An empty range answers every request with an error.
    set_range(32'd5, 32'd4);
    issue_request(bia_pkg::OP_ALLOCATE, 32'd0);
    issue_request(bia_pkg::OP_RELEASE, 32'd4);
    issue_request(bia_pkg::OP_RELEASE, 32'd5);

    // Oversized range: offsets past the map are invalid to release.
    set_range(32'd0, 32'hFFFF_FFFF);
    issue_request(bia_pkg::OP_RELEASE, 32'd1024);
    issue_request(bia_pkg::OP_RELEASE, 32'd2000);
    issue_request(bia_pkg::OP_ALLOCATE, 32'd0);

    // A tiny range leaves the hint past its end, so the search wraps.
    set_range(32'd0, 32'd3);
    repeat (5) issue_request(bia_pkg::OP_ALLOCATE, 32'd0);

    set_range($urandom() & 32'h7FFF_FFFF, 32'd0);
    set_range(cur_low, cur_low + 32'd47);
    random_requests(250);

    set_range(32'hFFFF_FC00, 32'hFFFF_FFFF);
    send_idle_pct <= 61;
    recv_idle_pct <= 7;
    random_requests(250);

    set_range(32'd0, 32'hFFFF_FFFF);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    random_requests(120);
    hold_toggle <= ~hold_toggle;
    random_requests(130);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Summary: %0d allocates and %0d releases over %0d range settings.",
             allocs, releases, range_settings);
    $display("Answers: %0d grants, %0d no-space, %0d invalid releases or empty ranges.",
             grants, no_space, invalid);
    if (fail_count == 0 && pending == 0) begin
      $display("bitmap_id_allocator test passed");
    end else begin
      $display("bitmap_id_allocator test failed");
    end
    $finish;
  end

endmodule
